// File: sv/mtet_pkg.sv
// Shared types, constants and register codes for the multi-turn encoder tracker.
package mtet_pkg;

    localparam int NUM_CHANNELS    = 5;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int CPT_LOG2        = $clog2(COUNTS_PER_TURN);
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

    localparam int ID_W      = 11;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CH_W      = 3;
    localparam int ENABLE_W  = 5;
    localparam int TURN_W    = 16;
    localparam int ABS_W     = 30;
    localparam int ANGLE_W   = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int RESET_ID_BASE = 513;

    // angle = absolute * 360 * 256 / (COUNTS_PER_TURN * 36)
    //       = absolute * 5 * 2^9 / COUNTS_PER_TURN (absolute * 5 / 16 at 8192)
    localparam int ANGLE_GAIN_LOG2 = 9;
    localparam int ANGLE_MUL_LOG2  = 2;   // multiply by 5 as (x << 2) + x
    localparam int ANGLE_SHIFT     = CPT_LOG2 - ANGLE_GAIN_LOG2;
    localparam int PROD_W          = ABS_W + ANGLE_MUL_LOG2 + 1;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 16;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_ENABLE = 3'd0,
        REG_ID_CHANNEL0    = 3'd1,
        REG_ID_CHANNEL1    = 3'd2,
        REG_ID_CHANNEL2    = 3'd3,
        REG_ID_CHANNEL3    = 3'd4,
        REG_ID_CHANNEL4    = 3'd5
    } cfg_reg_t;

    // One classified frame waiting for the unwrap pipeline.
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [WORD_W-1:0] position;
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] current;
    } frame_entry_t;

    // Handshake between the queue and the unwrap pipeline.
    typedef struct packed {
        logic         valid;
        frame_entry_t entry;
    } queue_out_t;

endpackage

// File: sv/mtet_front.sv
// Front end: configuration registers, identifier match and payload unpacking.
module mtet_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtet_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mtet_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [mtet_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                q_ready,
    output logic                                q_push,
    output mtet_pkg::frame_entry_t              q_entry
);

    logic [mtet_pkg::ENABLE_W-1:0] enable_reg;
    logic [mtet_pkg::ID_W-1:0]     id_reg [mtet_pkg::NUM_CHANNELS];
    logic [mtet_pkg::ID_W-1:0]     frame_id;
    logic                          hit;
    logic [mtet_pkg::CH_W-1:0]     hit_channel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            for (int c = 0; c < mtet_pkg::NUM_CHANNELS; c++) begin
                id_reg[c] <= mtet_pkg::ID_W'(mtet_pkg::RESET_ID_BASE + c);
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == mtet_pkg::REG_CHANNEL_ENABLE) begin
                enable_reg <= cfg_data[mtet_pkg::ENABLE_W-1:0];
            end
            for (int c = 0; c < mtet_pkg::NUM_CHANNELS; c++) begin
                if (cfg_index == mtet_pkg::CFG_IDX_W'(mtet_pkg::REG_ID_CHANNEL0 + c)) begin
                    id_reg[c] <= cfg_data[mtet_pkg::ID_W-1:0];
                end
            end
        end
    end

    assign frame_id = s_tuser[mtet_pkg::ID_W-1:0];

    // Scan from the top so the lowest enabled match wins.
    always_comb begin
        hit         = 1'b0;
        hit_channel = '0;
        for (int c = mtet_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
            if (enable_reg[c] && (id_reg[c] == frame_id)) begin
                hit         = 1'b1;
                hit_channel = mtet_pkg::CH_W'(c);
            end
        end
    end

    // All frames wait for queue space; unmatched ones are then taken and dropped.
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && s_tready && hit;

    assign q_entry.channel  = hit_channel;
    assign q_entry.position = {s_tdata[7:0],   s_tdata[15:8]};
    assign q_entry.speed    = {s_tdata[23:16], s_tdata[31:24]};
    assign q_entry.current  = {s_tdata[39:32], s_tdata[47:40]};

endmodule

// File: sv/mtet_queue.sv
// Two-entry queue that decouples frame classification from the unwrap pipeline.
module mtet_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mtet_pkg::frame_entry_t push_entry,
    output logic                   push_ready,
    input  logic                   pop,
    output mtet_pkg::queue_out_t   head
);

    mtet_pkg::frame_entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem[rd_ptr_reg];

endmodule

// File: sv/mtet_back.sv
// Back end: per-channel unwrap, absolute position and shaft angle pipeline.
module mtet_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtet_pkg::queue_out_t          head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtet_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mtet_pkg::M_TUSER_W-1:0] m_tuser
);

    // per-channel state
    logic [mtet_pkg::WORD_W-1:0]        last_pos_reg [mtet_pkg::NUM_CHANNELS];
    logic signed [mtet_pkg::TURN_W-1:0] turns_reg    [mtet_pkg::NUM_CHANNELS];

    // stage 1: unwrap
    logic                               s1_valid_reg;
    mtet_pkg::frame_entry_t             s1_entry_reg;
    logic signed [mtet_pkg::TURN_W-1:0] s1_turns_reg;
    // stage 2: absolute and scaled product
    logic                               s2_valid_reg;
    mtet_pkg::frame_entry_t             s2_entry_reg;
    logic signed [mtet_pkg::TURN_W-1:0] s2_turns_reg;
    logic signed [mtet_pkg::ABS_W-1:0]  s2_abs_reg;
    logic signed [mtet_pkg::PROD_W-1:0] s2_prod_reg;
    // stage 3: output register
    logic                               s3_valid_reg;
    mtet_pkg::frame_entry_t             s3_entry_reg;
    logic signed [mtet_pkg::TURN_W-1:0] s3_turns_reg;
    logic signed [mtet_pkg::ABS_W-1:0]  s3_abs_reg;
    logic signed [mtet_pkg::ANGLE_W-1:0] s3_angle_reg;

    logic s1_ready, s2_ready, s3_ready;
    logic [mtet_pkg::CH_IDX_W-1:0]       rd_idx;
    logic signed [mtet_pkg::WORD_W:0]    delta;
    logic signed [mtet_pkg::TURN_W-1:0]  turns_cur, turns_next;
    logic signed [mtet_pkg::ABS_W-1:0]   abs_next;
    logic signed [mtet_pkg::PROD_W-1:0]  abs_ext, prod_next, prod_biased;
    logic signed [mtet_pkg::PROD_W-1:0]  angle_full;

    assign s3_ready = !s3_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = head.valid && s1_ready;

    assign rd_idx    = head.entry.channel[mtet_pkg::CH_IDX_W-1:0];
    assign turns_cur = turns_reg[rd_idx];
    assign delta     = signed'({1'b0, head.entry.position}) -
                       signed'({1'b0, last_pos_reg[rd_idx]});

    // Step the turn count on a wrap, holding at the signed limits.
    always_comb begin
        turns_next = turns_cur;
        if (delta > (mtet_pkg::WORD_W+1)'(mtet_pkg::HALF_TURN)) begin
            if (turns_cur != {1'b1, {(mtet_pkg::TURN_W-1){1'b0}}}) begin
                turns_next = turns_cur - mtet_pkg::TURN_W'(1);
            end
        end else if (delta < -((mtet_pkg::WORD_W+1)'(mtet_pkg::HALF_TURN))) begin
            if (turns_cur != {1'b0, {(mtet_pkg::TURN_W-1){1'b1}}}) begin
                turns_next = turns_cur + mtet_pkg::TURN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < mtet_pkg::NUM_CHANNELS; c++) begin
                last_pos_reg[c] <= '0;
                turns_reg[c]    <= '0;
            end
        end else if (pop) begin
            last_pos_reg[rd_idx] <= head.entry.position;
            turns_reg[rd_idx]    <= turns_next;
        end
    end

    always_comb begin
        abs_next = (mtet_pkg::ABS_W'(s1_turns_reg) <<< mtet_pkg::CPT_LOG2) +
                   signed'({{(mtet_pkg::ABS_W-mtet_pkg::WORD_W){1'b0}},
                            s1_entry_reg.position});
        abs_ext   = mtet_pkg::PROD_W'(abs_next);
        prod_next = (abs_ext <<< mtet_pkg::ANGLE_MUL_LOG2) + abs_ext;
    end

    // Bias negatives so the arithmetic shift truncates toward zero.
    always_comb begin
        prod_biased = s2_prod_reg;
        if (s2_prod_reg[mtet_pkg::PROD_W-1]) begin
            prod_biased = s2_prod_reg +
                          mtet_pkg::PROD_W'((1 << mtet_pkg::ANGLE_SHIFT) - 1);
        end
        angle_full = prod_biased >>> mtet_pkg::ANGLE_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= head.valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_entry_reg <= head.entry;
            s1_turns_reg <= turns_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_entry_reg <= s1_entry_reg;
            s2_turns_reg <= s1_turns_reg;
            s2_abs_reg   <= abs_next;
            s2_prod_reg  <= prod_next;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_entry_reg <= s2_entry_reg;
            s3_turns_reg <= s2_turns_reg;
            s3_abs_reg   <= s2_abs_reg;
            s3_angle_reg <= angle_full[mtet_pkg::ANGLE_W-1:0];
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tuser  = {{(mtet_pkg::M_TUSER_W-mtet_pkg::CH_W){1'b0}}, s3_entry_reg.channel};
    assign m_tdata  = {6'b0, s3_angle_reg, s3_abs_reg, s3_turns_reg,
                       s3_entry_reg.current, s3_entry_reg.speed, s3_entry_reg.position};

endmodule

// File: sv/multi_turn_encoder_tracker.sv
// Multi-turn encoder tracker for five motor feedback channels. Each frame carries
// an 11-bit identifier on s_tuser and six big-endian payload bytes on s_tdata.
// Frames whose identifier matches no enabled channel are taken and dropped; a match
// (lowest enabled channel wins) yields one result with the unwrapped turn count,
// the absolute position and the output-shaft angle in 1/256 degree. One frame is
// taken every cycle while m_tready keeps up; each frame passes through the queue, then
// the unwrap, scale and output stage registers, and the read-modify-write of the
// per-channel turn state keeps pace with that rate. A two-entry queue sits between
// matching and unwrap; with m_tready low the block holds five matched frames before
// s_tready drops.
// Registers: 0 channel_enable, 1..5 id_channel0..4; write them only while idle.
module multi_turn_encoder_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtet_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte0 [7:0], data_byte1 [15:8], ... data_byte5 [47:40]
    input  logic [mtet_pkg::S_TDATA_W-1:0]      s_tdata,
    // frame_id [10:0], zeros above
    input  logic [mtet_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // raw_position [15:0], speed_word [31:16], current_word [47:32],
    // turn_count [63:48], absolute_position [93:64], shaft_angle [121:94], zeros above
    output logic [mtet_pkg::M_TDATA_W-1:0]      m_tdata,
    // channel [2:0], zeros above
    output logic [mtet_pkg::M_TUSER_W-1:0]      m_tuser
);

    logic                   q_ready;
    logic                   q_push;
    logic                   q_pop;
    mtet_pkg::frame_entry_t q_entry;
    mtet_pkg::queue_out_t   q_head;

    mtet_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    mtet_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head)
    );

    mtet_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // Absolute position keeps the low 13 bits of the raw position in its low bits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[64 +: mtet_pkg::CPT_LOG2] == m_tdata[0 +: mtet_pkg::CPT_LOG2]))
        else $error("absolute position low bits differ from raw position");

    // A non-negative absolute position never gives a negative angle; small negatives may give zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[93]) |-> !m_tdata[121])
        else $error("shaft angle negative for non-negative absolute position");

    // Reported channel is always a real channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[mtet_pkg::CH_W-1:0] < mtet_pkg::CH_W'(mtet_pkg::NUM_CHANNELS)))
        else $error("result channel out of range");

    // A frame is queued only when it was accepted on the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && s_tready))
        else $error("queue push without input transfer");
`endif

endmodule

// File: verif/multi_turn_encoder_tracker_tb.sv
// Self-checking testbench for the multi-turn encoder tracker stream block.
`timescale 1ns / 1ps

module multi_turn_encoder_tracker_tb;

    localparam int TURN_MAX     = 32767;
    localparam int TURN_MIN     = -32768;
    localparam int GEAR_RATIO   = 36;
    localparam int DEG_PER_TURN = 360;
    localparam int ANGLE_SCALE  = 256;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int WRAP_RUN     = 20;

    // indexes past the last register; writes to them must be ignored
    localparam logic [mtet_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mtet_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [mtet_pkg::WORD_W-1:0] WRAP_STEP =
        mtet_pkg::WORD_W'(mtet_pkg::HALF_TURN + 1);
    localparam logic [mtet_pkg::WORD_W-1:0] SLOW_STEP = 16'd4000;

    typedef struct {
        logic [mtet_pkg::CH_W-1:0]    channel;
        logic [mtet_pkg::WORD_W-1:0]  raw;
        logic [mtet_pkg::WORD_W-1:0]  speed;
        logic [mtet_pkg::WORD_W-1:0]  current;
        logic [mtet_pkg::TURN_W-1:0]  turns;
        logic [mtet_pkg::ABS_W-1:0]   absolute;
        logic [mtet_pkg::ANGLE_W-1:0] angle;
    } shaft_report_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mtet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mtet_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mtet_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [mtet_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mtet_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [mtet_pkg::M_TUSER_W-1:0]  m_tuser;

    // predictor copy of the configuration and per-channel unwrap state
    logic [mtet_pkg::ENABLE_W-1:0]      en_mask;
    logic [mtet_pkg::ID_W-1:0]          chan_id  [mtet_pkg::NUM_CHANNELS];
    logic [mtet_pkg::WORD_W-1:0]        last_pos [mtet_pkg::NUM_CHANNELS];
    logic signed [mtet_pkg::TURN_W-1:0] turn_cnt [mtet_pkg::NUM_CHANNELS];

    shaft_report_t pending_reports[$];
    int predicted_total = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = 36;
    int recv_idle_pct   = 48;

    multi_turn_encoder_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
        mismatches++;
    endtask

    // Unwrap one feedback frame against the channel history and queue the report if a channel matches.
    function automatic void predict_feedback(input logic [mtet_pkg::ID_W-1:0] fid,
                                             input logic [mtet_pkg::WORD_W-1:0] pos,
                                             input logic [mtet_pkg::WORD_W-1:0] spd,
                                             input logic [mtet_pkg::WORD_W-1:0] cur);
        int hit;
        int jump;
        int t;
        longint absv;
        shaft_report_t r;
        hit = -1;
        // descend so the lowest enabled match wins
        for (int c = mtet_pkg::NUM_CHANNELS - 1; c >= 0; c--)
            if (en_mask[c] && chan_id[c] == fid) hit = c;
        if (hit < 0) return;
        jump = int'(pos) - int'(last_pos[hit]);
        t = turn_cnt[hit];
        if (jump > mtet_pkg::HALF_TURN) begin
            if (t > TURN_MIN) t--;
        end else if (jump < -mtet_pkg::HALF_TURN) begin
            if (t < TURN_MAX) t++;
        end
        turn_cnt[hit] = mtet_pkg::TURN_W'(t);
        last_pos[hit] = pos;
        absv = longint'(pos) + longint'(t) * mtet_pkg::COUNTS_PER_TURN;
        r.channel  = mtet_pkg::CH_W'(hit);
        r.raw      = pos;
        r.speed    = spd;
        r.current  = cur;
        r.turns    = mtet_pkg::TURN_W'(t);
        r.absolute = mtet_pkg::ABS_W'(absv);
        r.angle    = mtet_pkg::ANGLE_W'(absv * DEG_PER_TURN * ANGLE_SCALE
                        / (longint'(mtet_pkg::COUNTS_PER_TURN) * GEAR_RATIO));
        pending_reports.push_back(r);
        predicted_total++;
    endfunction

    task automatic write_reg(input logic [mtet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mtet_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            mtet_pkg::REG_CHANNEL_ENABLE: en_mask = val[mtet_pkg::ENABLE_W-1:0];
            mtet_pkg::REG_ID_CHANNEL0, mtet_pkg::REG_ID_CHANNEL1, mtet_pkg::REG_ID_CHANNEL2,
            mtet_pkg::REG_ID_CHANNEL3, mtet_pkg::REG_ID_CHANNEL4:
                chan_id[idx - mtet_pkg::REG_ID_CHANNEL0] = val;
            default: ;
        endcase
    endtask

    task automatic send_frame(input logic [mtet_pkg::ID_W-1:0] fid,
                              input logic [mtet_pkg::WORD_W-1:0] pos,
                              input logic [mtet_pkg::WORD_W-1:0] spd,
                              input logic [mtet_pkg::WORD_W-1:0] cur);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= mtet_pkg::S_TDATA_W'({$urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur[7:0], cur[15:8], spd[7:0], spd[15:8], pos[7:0], pos[15:8]};
        s_tuser  <= {{(mtet_pkg::S_TUSER_W - mtet_pkg::ID_W){1'b0}}, fid};
        do @(posedge aclk); while (!s_tready);
        predict_feedback(fid, pos, spd, cur);
    endtask

    // Drain all results, then keep the inputs idle before the next step.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_disabled_channels();
        settle();
        send_frame(chan_id[0], 16'h1234, 16'h5678, 16'h9ABC);
        settle();
        write_reg(REG_SPARE_LO, 11'h7FF);
        write_reg(REG_SPARE_HI, 11'h000);
        // upper data bits fall outside the enable mask
        write_reg(mtet_pkg::REG_CHANNEL_ENABLE, 11'h7E0);
        send_frame(chan_id[1], 16'hFFFF, 16'h0000, 16'hFFFF);
        send_frame(chan_id[4], 16'h0000, 16'hFFFF, 16'h0000);
        settle();
        write_reg(mtet_pkg::REG_CHANNEL_ENABLE, 11'h01F);
        for (int c = 0; c < mtet_pkg::NUM_CHANNELS; c++)
            send_frame(chan_id[c], (c % 2) ? 16'hFFFF : 16'h0000, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_channel_ids();
        settle();
        write_reg(mtet_pkg::REG_ID_CHANNEL0, 11'd0);
        write_reg(mtet_pkg::REG_ID_CHANNEL1, 11'd2047);
        write_reg(mtet_pkg::REG_ID_CHANNEL2, 11'd700);
        write_reg(mtet_pkg::REG_ID_CHANNEL3, 11'd700);
        write_reg(mtet_pkg::REG_ID_CHANNEL4, 11'd1234);
        write_reg(mtet_pkg::REG_CHANNEL_ENABLE, 11'h7FF);
        send_frame(11'd0, 16'h0000, 16'h0000, 16'h0000);
        send_frame(11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(11'd700, 16'h4321, 16'h00FF, 16'hFF00);
        send_frame(11'd1234, 16'h8000, 16'h0001, 16'h8001);
        send_frame(11'd5, 16'h2222, 16'h3333, 16'h4444);
        settle();
        // with the lower duplicate disabled the upper one takes the frame
        write_reg(mtet_pkg::REG_CHANNEL_ENABLE, 11'b000_0001_1011);
        send_frame(11'd700, 16'h0101, 16'h0202, 16'h0303);
    endtask

    task automatic test_unwrap_edges();
        logic [mtet_pkg::WORD_W-1:0] path [7];
        path = '{16'd0, 16'd4096, 16'd8193, 16'd4097, 16'd0, 16'hFFFF, 16'd0};
        foreach (path[k])
            send_frame(chan_id[4], path[k], 16'(k), 16'(~k));
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int per_setting);
        logic [mtet_pkg::ENABLE_W-1:0] en;
        logic [mtet_pkg::ID_W-1:0]     fid;
        logic [mtet_pkg::WORD_W-1:0]   pos;
        logic [mtet_pkg::WORD_W-1:0]   spd;
        logic [mtet_pkg::WORD_W-1:0]   cur;
        int target;
        int c;
        int jump;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (2) begin
            settle();
            for (int k = 0; k < mtet_pkg::NUM_CHANNELS; k++) begin
                fid = mtet_pkg::ID_W'($urandom);
                case ($urandom_range(0, 9))
                    0: fid = '0;
                    1: fid = '1;
                    2: if (k > 0) fid = chan_id[k - 1];
                    default: ;
                endcase
                write_reg(mtet_pkg::CFG_IDX_W'(mtet_pkg::REG_ID_CHANNEL0 + k), fid);
            end
            en = mtet_pkg::ENABLE_W'($urandom_range(1, 31));
            if ($urandom_range(0, 3) == 0) en = '1;
            write_reg(mtet_pkg::REG_CHANNEL_ENABLE, {6'($urandom), en});
            target = predicted_total + per_setting;
            while (predicted_total < target) begin
                c = $urandom_range(0, mtet_pkg::NUM_CHANNELS - 1);
                if ($urandom_range(0, 99) < 85) begin
                    repeat (8)
                        if (!en_mask[c]) c = $urandom_range(0, mtet_pkg::NUM_CHANNELS - 1);
                    fid = chan_id[c];
                end else begin
                    fid = mtet_pkg::ID_W'($urandom);
                end
                // mostly plausible motion, with jumps around the half-turn boundary
                case ($urandom_range(0, 3))
                    0: jump = int'($urandom_range(0, 16384)) - mtet_pkg::COUNTS_PER_TURN;
                    1: jump = (mtet_pkg::HALF_TURN + int'($urandom_range(0, 3)) - 1)
                              * ($urandom_range(0, 1) ? 1 : -1);
                    2: jump = int'($urandom_range(0, 1000)) - 500;
                    default: jump = int'($urandom_range(0, 65535)) - int'(last_pos[c]);
                endcase
                pos = mtet_pkg::WORD_W'(int'(last_pos[c]) + jump);
                spd = mtet_pkg::WORD_W'($urandom);
                cur = mtet_pkg::WORD_W'($urandom);
                if ($urandom_range(0, 15) == 0) spd = '1;
                if ($urandom_range(0, 15) == 0) cur = '0;
                send_frame(fid, pos, spd, cur);
            end
        end
    endtask

    task automatic test_turn_runs();
        settle();
        write_reg(mtet_pkg::REG_ID_CHANNEL0, 11'd321);
        write_reg(mtet_pkg::REG_ID_CHANNEL1, 11'd1800);
        write_reg(mtet_pkg::REG_CHANNEL_ENABLE, 11'b000_0000_0011);
        // falling steps just past half a turn count up
        repeat (WRAP_RUN)
            send_frame(11'd321, last_pos[0] - WRAP_STEP, mtet_pkg::WORD_W'($urandom),
                       mtet_pkg::WORD_W'($urandom));
        while (last_pos[0] != 16'hFFFF)
            send_frame(11'd321, (last_pos[0] > 16'hFFFF - SLOW_STEP) ? 16'hFFFF
                                : last_pos[0] + SLOW_STEP, 16'h1111, 16'h2222);
        send_frame(11'd321, 16'h0000, 16'h3333, 16'h4444);
        // rising steps count down
        repeat (WRAP_RUN)
            send_frame(11'd1800, last_pos[1] + WRAP_STEP, mtet_pkg::WORD_W'($urandom),
                       mtet_pkg::WORD_W'($urandom));
        while (last_pos[1] != 16'h0000)
            send_frame(11'd1800, (last_pos[1] < SLOW_STEP) ? 16'h0000
                                 : last_pos[1] - SLOW_STEP, 16'h5555, 16'h6666);
        send_frame(11'd1800, 16'hFFFF, 16'h7777, 16'h8888);
    endtask

    always @(posedge aclk) begin
        shaft_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("result with none pending, channel",
                                m_tuser[mtet_pkg::CH_W-1:0], 0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tuser[mtet_pkg::CH_W-1:0] !== want.channel)
                    report_mismatch("channel", m_tuser[mtet_pkg::CH_W-1:0], want.channel);
                if (m_tdata[15:0] !== want.raw)
                    report_mismatch("raw_position", m_tdata[15:0], want.raw);
                if (m_tdata[31:16] !== want.speed)
                    report_mismatch("speed_word", m_tdata[31:16], want.speed);
                if (m_tdata[47:32] !== want.current)
                    report_mismatch("current_word", m_tdata[47:32], want.current);
                if (m_tdata[63:48] !== want.turns)
                    report_mismatch("turn_count", m_tdata[63:48], want.turns);
                if (m_tdata[93:64] !== want.absolute)
                    report_mismatch("absolute_position", m_tdata[93:64], want.absolute);
                if (m_tdata[121:94] !== want.angle)
                    report_mismatch("shaft_angle", m_tdata[121:94], want.angle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        en_mask = '0;
        for (int c = 0; c < mtet_pkg::NUM_CHANNELS; c++) begin
            chan_id[c]  = mtet_pkg::ID_W'(mtet_pkg::RESET_ID_BASE + c);
            last_pos[c] = '0;
            turn_cnt[c] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_disabled_channels();
        test_channel_ids();
        test_unwrap_edges();
        test_random_traffic(36, 48, 170);
        test_random_traffic(48, 36, 170);
        test_random_traffic(0, 0, 170);
        test_turn_runs();
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: multi_turn_encoder_tracker.f
sv/mtet_pkg.sv
sv/mtet_front.sv
sv/mtet_queue.sv
sv/mtet_back.sv
sv/multi_turn_encoder_tracker.sv
verif/multi_turn_encoder_tracker_tb.sv
